// ===== rtl/pmcf_pkg.sv =====
// pmcf_pkg: shared constants, types and functions for the packet-mode crc filter
// no dependencies; imported by every module of the block but pmcf_ram
package pmcf_pkg;

    // store sizing, two banks so one packet fills while the previous drains
    localparam int STORE_DEPTH = 96;
    localparam int POS_W       = 7;
    localparam int RAM_DEPTH   = 2 * STORE_DEPTH;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);

    // crc-16 ccitt
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    // packet layout
    localparam int          LEN_UNIT   = 24;
    localparam int          CRC_BYTES  = 2;
    localparam int          HDR_BYTES  = 5;
    localparam int          DATA_OFS   = 3;
    localparam logic [1:0]  FL_FIRST   = 2'd2;
    localparam logic [3:0]  GT_DATA    = 4'd6;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // payload byte counts
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    typedef enum logic [1:0] {
        ST_DELIVERED = 2'd0,
        ST_FILTERED  = 2'd1,
        ST_CRC_ERR   = 2'd2
    } t_status;

    // one finished packet handed from front to back
    typedef struct packed {
        logic             bank;
        t_status          status;
        logic [POS_W-1:0] udl;
    } t_job;

    // one byte of crc, msb first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = (c << 1) ^ (((c & CRC_MSB) != 16'h0000) ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // packet length from the two length bits of byte 0
    function automatic logic [POS_W-1:0] len_of(input logic [1:0] code);
        return POS_W'(LEN_UNIT * (int'(code) + 1));
    endfunction

endpackage

// ===== rtl/pmcf_ram.sv =====
// pmcf_ram: generic single-write, single-read ram with registered read data
// no dependencies
module pmcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port; read data holds while i_re is low
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pmcf_front.sv =====
// pmcf_front: byte intake, crc, header capture and per-packet decision
// depends on pmcf_pkg; writes packet bytes into the shared store, pushes jobs
module pmcf_front
    import pmcf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_sop,
    input  logic [9:0]        i_address,
    output logic              o_ram_we,
    output logic [RAM_AW-1:0] o_ram_addr,
    output logic [7:0]        o_ram_wdata,
    output logic              o_push,
    output t_job              o_job
);

    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_crc;
    logic [POS_W-1:0] r_len;
    logic [7:0]       r_b0;
    logic [7:0]       r_b1;
    logic [POS_W-1:0] r_udl;
    logic [3:0]       r_type_nib;
    logic [7:0]       r_prev;
    logic [3:0]       r_group_type;
    logic             r_bank;

    logic [POS_W-1:0] pos_eff;
    logic [POS_W-1:0] len_eff;
    logic [15:0]      crc_base;
    logic [15:0]      crc_next;
    logic             crc_run;
    logic             finish;
    logic             crc_ok;
    logic             addr_ok;
    logic             take_type;
    logic [3:0]       type_next;
    logic [POS_W-1:0] cap;
    logic [POS_W-1:0] udl_sat;
    t_status          status;

    // position, length and crc seen by this byte
    always_comb begin
        pos_eff  = i_sop ? '0 : r_pos;
        len_eff  = (pos_eff == '0) ? len_of(i_byte[7:6]) : r_len;
        crc_base = (pos_eff == '0) ? CRC_INIT : r_crc;
        crc_run  = ({1'b0, pos_eff} + (POS_W+1)'(CRC_BYTES)) < {1'b0, len_eff};
        crc_next = crc_run ? crc_update(crc_base, i_byte) : crc_base;
        finish   = ({1'b0, pos_eff} + (POS_W+1)'(1)) >= {1'b0, len_eff};
    end

    // end-of-packet checks: crc, address, group type, useful length
    always_comb begin
        crc_ok    = ({r_prev, i_byte} ^ CRC_INIT) == crc_base;
        addr_ok   = {r_b0[1:0], r_b1} == i_address;
        take_type = (r_b0[3:2] == FL_FIRST);
        type_next = take_type ? r_type_nib : r_group_type;
        cap       = r_len - POS_W'(HDR_BYTES);
        udl_sat   = (r_udl > cap) ? cap : r_udl;
        if (!crc_ok) begin
            status = ST_CRC_ERR;
        end else if (!addr_ok || type_next != GT_DATA) begin
            status = ST_FILTERED;
        end else begin
            status = ST_DELIVERED;
        end
    end

    // store write for every accepted byte
    always_comb begin
        o_ram_we    = i_accept && (int'(pos_eff) < STORE_DEPTH);
        o_ram_addr  = (r_bank ? RAM_AW'(STORE_DEPTH) : '0) + RAM_AW'(pos_eff);
        o_ram_wdata = i_byte;
        o_push      = i_accept && finish;
        o_job.bank   = r_bank;
        o_job.status = status;
        o_job.udl    = udl_sat;
    end

    // header fields only need capturing at their positions
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_prev <= i_byte;
            if (pos_eff == POS_W'(0)) begin
                r_b0 <= i_byte;
            end
            if (pos_eff == POS_W'(1)) begin
                r_b1 <= i_byte;
            end
            if (pos_eff == POS_W'(2)) begin
                r_udl <= i_byte[6:0];
            end
            if (pos_eff == POS_W'(DATA_OFS)) begin
                r_type_nib <= i_byte[3:0];
            end
        end
    end

    // position, crc, bank and group type
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_crc        <= CRC_INIT;
            r_len        <= '0;
            r_group_type <= '0;
            r_bank       <= 1'b0;
        end else if (i_accept) begin
            r_len <= len_eff;
            if (finish) begin
                r_pos  <= '0;
                r_crc  <= CRC_INIT;
                r_bank <= ~r_bank;
                if (crc_ok && addr_ok && take_type) begin
                    r_group_type <= r_type_nib;
                end
            end else begin
                r_pos <= pos_eff + POS_W'(1);
                r_crc <= crc_next;
            end
        end
    end

endmodule

// ===== rtl/pmcf_queue.sv =====
// pmcf_queue: two-entry job queue between front and back
// depends on pmcf_pkg for t_job
module pmcf_queue
    import pmcf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/pmcf_back.sv =====
// pmcf_back: drains one packet job, reading payload pairs from the store
// depends on pmcf_pkg; drives the result channel through an output register
module pmcf_back
    import pmcf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_job              i_job,
    output logic              o_pop,
    output logic              o_ram_re,
    output logic [RAM_AW-1:0] o_ram_raddr,
    input  logic [7:0]        i_ram_rdata,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output t_status           o_status,
    output logic [7:0]        o_first,
    output logic [7:0]        o_second,
    output logic [1:0]        o_count,
    output logic              o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_HOLD,
        S_STAT
    } t_state;

    t_state           r_state;
    logic [POS_W-1:0] r_idx;
    logic [7:0]       r_first;
    logic             r_valid;
    logic             r_kind;
    t_status          r_status;
    logic [7:0]       r_d0;
    logic [7:0]       r_d1;
    logic [1:0]       r_count;
    logic             r_last;

    logic              out_free;
    logic              load;
    logic              pair;
    logic [RAM_AW-1:0] base;

    // read address of the byte pair being fetched
    always_comb begin
        out_free    = !r_valid || i_ready;
        load        = ((r_state == S_HOLD) || (r_state == S_STAT)) && out_free;
        pair        = ({1'b0, r_idx} + (POS_W+1)'(1)) < {1'b0, i_job.udl};
        base        = (i_job.bank ? RAM_AW'(STORE_DEPTH) : '0) + RAM_AW'(DATA_OFS)
                      + RAM_AW'(r_idx);
        o_ram_re    = (r_state == S_RD_A) || (r_state == S_RD_B);
        o_ram_raddr = (r_state == S_RD_B) ? base + RAM_AW'(1) : base;
        o_pop       = (r_state == S_STAT) && out_free;
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            // output valid: set on a load, cleared once the transfer completes
            if (load) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (!i_empty) begin
                        if (i_job.status != ST_DELIVERED || i_job.udl == '0) begin
                            r_state <= S_STAT;
                        end else begin
                            r_state <= S_RD_A;
                        end
                    end
                end
                S_RD_A: begin
                    r_state <= S_RD_B;
                end
                S_RD_B: begin
                    r_first <= i_ram_rdata;
                    r_state <= S_HOLD;
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_kind   <= KIND_PAYLOAD;
                        r_status <= ST_DELIVERED;
                        r_d0     <= r_first;
                        r_d1     <= pair ? i_ram_rdata : 8'h00;
                        r_count  <= pair ? CNT_TWO : CNT_ONE;
                        r_last   <= 1'b0;
                        r_idx    <= r_idx + POS_W'(2);
                        if (({1'b0, r_idx} + (POS_W+1)'(2)) >= {1'b0, i_job.udl}) begin
                            r_state <= S_STAT;
                        end else begin
                            r_state <= S_RD_A;
                        end
                    end
                end
                S_STAT: begin
                    if (out_free) begin
                        r_kind   <= KIND_STATUS;
                        r_status <= i_job.status;
                        r_d0     <= 8'h00;
                        r_d1     <= 8'h00;
                        r_count  <= CNT_NONE;
                        r_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_kind   = r_kind;
    assign o_status = r_status;
    assign o_first  = r_d0;
    assign o_second = r_d1;
    assign o_count  = r_count;
    assign o_last   = r_last;

endmodule

// ===== rtl/packet_mode_crc_filter_top.sv =====
// packet_mode_crc_filter_top: packet-mode byte stream crc and address filter
// depends on pmcf_pkg, pmcf_ram, pmcf_front, pmcf_queue, pmcf_back
//
// usage: bytes enter on the slave stream one per transfer (tdata = byte,
// tuser = start-of-packet mark). packet length comes from byte 0, the crc
// is checked on the last byte, and each packet yields its payload pairs (if
// delivered) followed by one status transfer with tlast high on the master
// stream. the packet address register sits at apb byte address 0.
// the front takes one byte per cycle while the two-entry job queue has
// room; bytes land in one of two store banks, so a packet can fill while
// the previous one drains. the back reads each payload pair with two
// store reads through the single read port, then loads it into the
// output register; the status follows as its own output load, and for a
// filtered packet it goes straight from the job queue to that load. when
// the receiver stalls, the output register holds, the queue fills after
// two packets and tready on the slave side drops.
// reset clears position, crc, group type, queue and output valid; the
// store itself is not cleared and needs no clearing pass.
module packet_mode_crc_filter_top
    import pmcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] packet_byte
    input  logic        i_s_tuser,   // [0] start_of_packet
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [1:0] status, [9:2] data_first,
                                     // [17:10] data_second, [19:18] byte_count
    output logic        o_m_tuser,   // [0] kind
    output logic        o_m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [9:0]        r_packet_address;
    logic              accept;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic              push;
    t_job              job_in;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    t_job              job_head;
    logic              m_kind;
    t_status           m_status;
    logic [7:0]        m_first;
    logic [7:0]        m_second;
    logic [1:0]        m_count;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {22'h0, r_packet_address} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_address <= '0;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_packet_address <= pwdata[9:0];
        end
    end

    // input transfer
    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    pmcf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .i_sop       (i_s_tuser),
        .i_address   (r_packet_address),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_push      (push),
        .o_job       (job_in)
    );

    pmcf_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pmcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (job_head)
    );

    pmcf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_job       (job_head),
        .o_pop       (pop),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_kind      (m_kind),
        .o_status    (m_status),
        .o_first     (m_first),
        .o_second    (m_second),
        .o_count     (m_count),
        .o_last      (o_m_tlast)
    );

    // result packing
    assign o_m_tdata = {4'h0, m_count, m_second, m_first, m_status};
    assign o_m_tuser = m_kind;

endmodule

// ===== sim/tb_packet_mode_crc_filter_top.sv =====
`timescale 1ns / 1ps
// tb_packet_mode_crc_filter_top: self-checking bench for the packet-mode crc filter
// depends on pmcf_pkg and packet_mode_crc_filter_top; tracks the byte stream and checks
// every payload and status transfer against its own prediction
module tb_packet_mode_crc_filter_top;
    import pmcf_pkg::*;

    localparam logic [2:0] REG_PACKET_ADDRESS = 3'd0;
    localparam int         DRAIN_CYCLES       = 200;
    localparam int         WAIT_GUARD         = 50000;

    typedef struct packed {
        logic [7:0] b;
        logic       sop;
    } t_stream_byte;

    typedef struct packed {
        logic       kind;
        t_status    status;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [1:0] cnt;
        logic       last;
    } t_filter_result;

    // clock, reset and block inputs, all known from time zero
    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_valid  = 1'b0;
    logic [7:0]  s_data   = 8'h00;
    logic        s_user   = 1'b0;
    logic        m_ready  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'h0;

    wire         o_s_tready;
    wire         o_m_tvalid;
    wire [23:0]  o_m_tdata;
    wire         o_m_tuser;
    wire         o_m_tlast;
    wire [31:0]  prdata;
    wire         pready;

    // stimulus and expectation stores
    t_stream_byte   byte_backlog[$];
    t_filter_result pending_results[$];
    int             mismatches      = 0;
    int             sender_idle_pct = 0;
    int             recv_stall_pct  = 0;
    int             phase_bytes     = 0;
    bit             at_boundary     = 1'b1;

    // shadow copy of the filter state
    logic [7:0]  shadow_store [STORE_DEPTH];
    logic [6:0]  rx_pos       = '0;
    logic [15:0] rx_crc       = CRC_INIT;
    logic [3:0]  stored_type  = '0;
    int          pkt_len      = 0;
    logic [9:0]  accept_addr  = '0;

    packet_mode_crc_filter_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // crc-16 ccitt, one input bit at a time
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c;
        for (int k = 7; k >= 0; k--) begin
            if (r[15] ^ b[k]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic void add_result(input logic kind, input t_status st, input logic [7:0] d0,
                                       input logic [7:0] d1, input logic [1:0] cnt,
                                       input logic last);
        t_filter_result r;
        r.kind   = kind;
        r.status = st;
        r.d0     = d0;
        r.d1     = d1;
        r.cnt    = cnt;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    // crc, address and type checks on a completed packet, then the payload pairs
    function automatic void close_packet();
        logic [15:0] rx;
        int          udl;
        int          cap;
        rx = {shadow_store[pkt_len-2], shadow_store[pkt_len-1]} ^ 16'hFFFF;
        if (rx != rx_crc) begin
            add_result(KIND_STATUS, ST_CRC_ERR, 8'h00, 8'h00, CNT_NONE, 1'b1);
            return;
        end
        if ({shadow_store[0][1:0], shadow_store[1]} != accept_addr) begin
            add_result(KIND_STATUS, ST_FILTERED, 8'h00, 8'h00, CNT_NONE, 1'b1);
            return;
        end
        if (shadow_store[0][3:2] == FL_FIRST) begin
            stored_type = shadow_store[3][3:0];
        end
        if (stored_type != GT_DATA) begin
            add_result(KIND_STATUS, ST_FILTERED, 8'h00, 8'h00, CNT_NONE, 1'b1);
            return;
        end
        udl = int'(shadow_store[2][6:0]);
        cap = pkt_len - HDR_BYTES;
        if (udl > cap) begin
            udl = cap;
        end
        for (int i = 0; i < udl; i += 2) begin
            if (i + 1 < udl) begin
                add_result(KIND_PAYLOAD, ST_DELIVERED, shadow_store[DATA_OFS+i],
                           shadow_store[DATA_OFS+i+1], CNT_TWO, 1'b0);
            end else begin
                add_result(KIND_PAYLOAD, ST_DELIVERED, shadow_store[DATA_OFS+i], 8'h00,
                           CNT_ONE, 1'b0);
            end
        end
        add_result(KIND_STATUS, ST_DELIVERED, 8'h00, 8'h00, CNT_NONE, 1'b1);
    endfunction

    // one accepted byte: position, length, crc, and the packet close on its last byte
    function automatic void track_byte(input logic [7:0] b, input logic sop);
        if (sop) begin
            rx_pos = '0;
            rx_crc = CRC_INIT;
        end
        if (rx_pos == 0) begin
            rx_crc  = CRC_INIT;
            pkt_len = LEN_UNIT * (int'(b[7:6]) + 1);
        end
        shadow_store[rx_pos] = b;
        if (int'(rx_pos) + 2 < pkt_len) begin
            rx_crc = crc_byte(rx_crc, b);
        end
        if (int'(rx_pos) + 1 < pkt_len) begin
            rx_pos = rx_pos + 7'd1;
        end else begin
            close_packet();
            rx_pos = '0;
            rx_crc = CRC_INIT;
        end
    endfunction

    // build one packet with a valid trailer, optionally corrupted or cut short
    task automatic queue_packet(input logic [1:0] lc, input logic [1:0] fl, input logic [9:0] adr,
                                input logic [6:0] udl, input logic [3:0] gt, input bit bad_crc,
                                input bit mark, input int keep);
        logic [7:0]   pk [STORE_DEPTH];
        logic [15:0]  c;
        int           len;
        t_stream_byte sb;
        len   = LEN_UNIT * (int'(lc) + 1);
        pk[0] = {lc, 2'($urandom_range(3)), fl, adr[9:8]};
        pk[1] = adr[7:0];
        pk[2] = {1'($urandom_range(1)), udl};
        pk[3] = {4'($urandom_range(15)), gt};
        for (int i = 4; i < len - CRC_BYTES; i++) begin
            pk[i] = 8'($urandom_range(255));
        end
        c = CRC_INIT;
        for (int i = 0; i < len - CRC_BYTES; i++) begin
            c = crc_byte(c, pk[i]);
        end
        pk[len-2] = ~c[15:8];
        pk[len-1] = ~c[7:0];
        // corrupt one byte past the length, address and useful-length bytes
        if (bad_crc) begin
            pk[$urandom_range(len - 1, 3)] ^= 8'($urandom_range(255, 1));
        end
        for (int i = 0; i < len && i < keep; i++) begin
            sb.b   = pk[i];
            sb.sop = (i == 0) && (mark || !at_boundary);
            byte_backlog.push_back(sb);
        end
        phase_bytes += (keep < len) ? keep : len;
        at_boundary  = (keep >= len);
    endtask

    // loose bytes with random start marks
    task automatic queue_noise(input int n);
        t_stream_byte sb;
        for (int i = 0; i < n; i++) begin
            sb.b   = 8'($urandom_range(255));
            sb.sop = ($urandom_range(99) < 15);
            byte_backlog.push_back(sb);
        end
        phase_bytes += n;
        at_boundary  = 1'b0;
    endtask

    // apb write: setup cycle, then access cycle
    task automatic write_packet_address(input logic [9:0] adr);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_PACKET_ADDRESS;
        pwdata  <= {22'h0, adr};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        accept_addr = adr;
    endtask

    // wait for the stream to empty and every result to arrive, then let the block settle
    task automatic settle();
        int guard;
        guard = 0;
        while (byte_backlog.size() != 0 || s_valid) begin
            @(negedge i_clk);
        end
        while (pending_results.size() != 0 && guard < WAIT_GUARD) begin
            @(negedge i_clk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
            pending_results.delete();
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // slave-side driver
    always @(posedge i_clk) begin
        t_stream_byte sb;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || o_s_tready) begin
            if (byte_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                sb = byte_backlog.pop_front();
                s_valid <= 1'b1;
                s_data  <= sb.b;
                s_user  <= sb.sop;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predict on each input transfer, check each output transfer
    always @(posedge i_clk) begin
        t_filter_result want;
        if (i_rst_n) begin
            if (s_valid && o_s_tready) begin
                track_byte(s_data, s_user);
            end
            if (o_m_tvalid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result tuser=%b tdata=%h tlast=%b",
                                              o_m_tuser, o_m_tdata, o_m_tlast));
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_tuser !== want.kind || o_m_tdata[1:0] !== want.status ||
                        o_m_tdata[9:2] !== want.d0 || o_m_tdata[17:10] !== want.d1 ||
                        o_m_tdata[19:18] !== want.cnt || o_m_tlast !== want.last) begin
                        report_mismatch($sformatf(
                            "got kind %b st %0d d %h %h cnt %0d last %b, want %b %0d %h %h %0d %b",
                            o_m_tuser, o_m_tdata[1:0], o_m_tdata[9:2], o_m_tdata[17:10],
                            o_m_tdata[19:18], o_m_tlast, want.kind, want.status, want.d0,
                            want.d1, want.cnt, want.last));
                    end
                end
            end
        end
    end

    // sequence: reset, directed packets, then four random phases
    initial begin
        logic [9:0] phase_addr [4];
        logic [9:0] adr;
        logic [6:0] udl;
        logic [3:0] gt;
        logic [1:0] fl;
        int         lc;
        int         cap;
        int         keep;
        int         r;
        int         phase_pkts;
        phase_addr[0] = 10'h3FF;
        phase_addr[1] = 10'h000;
        phase_addr[2] = 10'($urandom_range(1023));
        phase_addr[3] = 10'h155;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_packet_address(phase_addr[0]);
        adr = phase_addr[0];
        // first byte after reset without a start mark, odd length
        queue_packet(2'd0, FL_FIRST, adr, 7'd19, GT_DATA, 1'b0, 1'b0, STORE_DEPTH);
        // useful length beyond the payload, type inherited from the first packet
        queue_packet(2'd0, 2'd3, adr, 7'd127, 4'd0, 1'b0, 1'b1, STORE_DEPTH);
        // partial packet dropped by a resync, then a crc error
        queue_packet(2'd2, FL_FIRST, adr, 7'd30, GT_DATA, 1'b0, 1'b1, 10);
        queue_packet(2'd0, FL_FIRST, adr, 7'd10, GT_DATA, 1'b1, 1'b1, STORE_DEPTH);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 59;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 59;
                end
                default: begin
                    sender_idle_pct = 12;
                    recv_stall_pct  = 12;
                end
            endcase
            if (ph != 0) begin
                write_packet_address(phase_addr[ph]);
            end
            phase_bytes = 0;
            phase_pkts  = 0;
            // mostly well-formed packets, some noise and cut-short ones
            while (phase_bytes < 24 || phase_pkts < 1 || !at_boundary) begin
                if ($urandom_range(99) < 5) begin
                    queue_noise($urandom_range(8, 1));
                end else begin
                    r   = $urandom_range(99);
                    lc  = (r < 80) ? 0 : (r < 92) ? 1 : (r < 97) ? 2 : 3;
                    cap = LEN_UNIT * (lc + 1) - HDR_BYTES;
                    adr = ($urandom_range(99) < 80) ? accept_addr : 10'($urandom_range(1023));
                    fl  = ($urandom_range(99) < 50) ? FL_FIRST : 2'($urandom_range(3));
                    gt  = ($urandom_range(99) < 80) ? GT_DATA : 4'($urandom_range(15));
                    r   = $urandom_range(9);
                    udl = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 :
                          (r == 2) ? 7'($urandom_range(127)) : 7'($urandom_range(cap));
                    keep = ($urandom_range(99) < 8) ?
                           $urandom_range(LEN_UNIT * (lc + 1) - 1, 1) : STORE_DEPTH;
                    queue_packet(2'(lc), fl, adr, udl, gt, $urandom_range(99) < 10,
                                 $urandom_range(99) >= 20, keep);
                    if (keep >= STORE_DEPTH) begin
                        phase_pkts++;
                    end
                end
            end
            settle();
        end

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // hard stop
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
